@@ hw/rtl/http_header_scanner_unit_assert.svh @@
// assertion macros used by the header scanner rtl
`ifndef HTTP_HEADER_SCANNER_UNIT_ASSERT_SVH
`define HTTP_HEADER_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define HHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hhs assertion failed");
// next-cycle implication
`define HHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hhs assertion failed");
`else
`define HHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define HHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/hhs_pkg.sv @@
// types, phase codes and match patterns for the header scanner
package hhs_pkg;

    localparam logic [1:0] PH_LINE     = 2'd0;
    localparam logic [1:0] PH_SKIP     = 2'd1;
    localparam logic [1:0] PH_SKIP_END = 2'd2;
    localparam logic [1:0] PH_BODY     = 2'd3;

    localparam logic [4:0] PFX_LEN      = 5'd16;
    localparam logic [4:0] CHK_LEN      = 5'd26;
    localparam logic [4:0] MIN_LEN_LINE = 5'd17;
    localparam logic [4:0] POS_MAX      = 5'd31;
    localparam logic [7:0] CR_BYTE      = 8'h0D;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;

    typedef struct packed {
        logic [1:0]  phase;
        logic [4:0]  line_pos;
        logic        prefix_match;
        logic        chunk_match;
        logic [31:0] len_acc;
        logic [31:0] len_value;
        logic        chunked;
    } t_state;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        header_done;
        logic [31:0] content_length;
        logic        chunked_seen;
    } t_result;

    function automatic t_state reset_state();
        t_state s;
        s.phase        = PH_LINE;
        s.line_pos     = 5'd0;
        s.prefix_match = 1'b1;
        s.chunk_match  = 1'b1;
        s.len_acc      = 32'd0;
        s.len_value    = 32'hFFFF_FFFF;
        s.chunked      = 1'b0;
        return s;
    endfunction

    // "Content-Length: "
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = " ";
        endcase
        return c;
    endfunction

    // "Transfer-Encoding: chunked"
    function automatic logic [7:0] chunk_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "T";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "E";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            5'd17:   c = ":";
            5'd18:   c = " ";
            5'd19:   c = "c";
            5'd20:   c = "h";
            5'd21:   c = "u";
            5'd22:   c = "n";
            5'd23:   c = "k";
            5'd24:   c = "e";
            5'd25:   c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/http_header_scanner_unit.sv @@
// The result word for a byte is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the scan state and the result register update
// in the same edge, and a waiting result does not block the next byte while
// the downstream side takes one word per cycle.
// Reset (synchronous, active low): scanner at start of a header line, length -1,
// chunked flag clear, no result pending.
`include "http_header_scanner_unit_assert.svh"

module http_header_scanner_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_new_response,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_body_valid,
    output logic [7:0]         o_body_byte,
    output logic               o_header_done,
    output logic signed [31:0] o_content_length,
    output logic               o_chunked_seen
);
    import hhs_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    hhs_step u_step (
        .i_state        (r_state),
        .i_data_byte    (i_data_byte),
        .i_new_response (i_new_response),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= reset_state();
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state <= n_state;
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_body_valid     = r_result.body_valid;
    assign o_body_byte      = r_result.body_byte;
    assign o_header_done    = r_result.header_done;
    assign o_content_length = r_result.content_length;
    assign o_chunked_seen   = r_result.chunked_seen;

    `HHS_ASSERT_NOW(a_body_after_header, i_clk, i_rst_n, o_out_valid && o_body_valid, o_header_done)
    `HHS_ASSERT_NOW(a_byte_zero_off_body, i_clk, i_rst_n, o_out_valid && !o_body_valid, o_body_byte == 8'd0)
    `HHS_ASSERT_NOW(a_len_neg_only_none, i_clk, i_rst_n, o_out_valid && o_content_length[31], o_content_length == 32'hFFFF_FFFF)
    `HHS_ASSERT_NOW(a_pos_only_in_line, i_clk, i_rst_n, r_state.phase != PH_LINE, r_state.line_pos == 5'd0)
    `HHS_ASSERT_NEXT(a_body_sticks, i_clk, i_rst_n, r_state.phase == PH_BODY && !(in_accept && i_new_response), r_state.phase == PH_BODY)

endmodule

@@ hw/rtl/hhs_step.sv @@
// next-state and result logic for one byte of the response stream
module hhs_step (
    input  hhs_pkg::t_state  i_state,
    input  logic [7:0]       i_data_byte,
    input  logic             i_new_response,
    output hhs_pkg::t_state  o_state,
    output hhs_pkg::t_result o_result
);
    import hhs_pkg::*;

    t_state     base;
    t_state     nxt;
    logic       is_body;
    logic [31:0] acc_times_ten;

    assign base          = i_new_response ? reset_state() : i_state;
    assign acc_times_ten = {base.len_acc[28:0], 3'b000} + {base.len_acc[30:0], 1'b0};

    always_comb begin
        nxt     = base;
        is_body = 1'b0;
        unique case (base.phase)
            PH_LINE: begin
                if (i_data_byte == CR_BYTE) begin
                    if (base.prefix_match && (base.line_pos >= MIN_LEN_LINE) &&
                        !base.len_acc[31]) begin
                        nxt.len_value = base.len_acc;
                    end
                    if (base.chunk_match && (base.line_pos == CHK_LEN)) begin
                        nxt.chunked = 1'b1;
                    end
                    nxt.phase        = (base.line_pos == 5'd0) ? PH_SKIP_END : PH_SKIP;
                    nxt.line_pos     = 5'd0;
                    nxt.prefix_match = 1'b1;
                    nxt.chunk_match  = 1'b1;
                    nxt.len_acc      = 32'd0;
                end else begin
                    if (base.line_pos < PFX_LEN) begin
                        if (i_data_byte != prefix_char(base.line_pos[3:0])) begin
                            nxt.prefix_match = 1'b0;
                        end
                    end else begin
                        // digits past the prefix, wrapping, no digit check
                        nxt.len_acc = acc_times_ten + {24'd0, i_data_byte}
                                      - {24'd0, DIGIT_ZERO};
                    end
                    if (base.line_pos >= CHK_LEN ||
                        i_data_byte != chunk_char(base.line_pos)) begin
                        nxt.chunk_match = 1'b0;
                    end
                    if (base.line_pos != POS_MAX) begin
                        nxt.line_pos = base.line_pos + 5'd1;
                    end
                end
            end
            PH_SKIP:     nxt.phase = PH_LINE;
            PH_SKIP_END: nxt.phase = PH_BODY;
            PH_BODY:     is_body   = 1'b1;
            default:     nxt.phase = PH_LINE;
        endcase
    end

    assign o_state                 = nxt;
    assign o_result.body_valid     = is_body;
    assign o_result.body_byte      = is_body ? i_data_byte : 8'd0;
    assign o_result.header_done    = nxt.phase[1];
    assign o_result.content_length = nxt.len_value;
    assign o_result.chunked_seen   = nxt.chunked;

endmodule
